// ===== design/xdbt_pkg.sv =====
// shared types and constants of the xor distance bucket table
package xdbt_pkg;

    localparam int unsigned NUM_BUCKETS = 160;
    localparam int unsigned ID_BITS     = 160;
    localparam int unsigned MAX_RES     = 20;
    localparam int unsigned CHUNKS      = 5;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_PING   = 2'd1,
        OP_QUERY  = 2'd2
    } t_opcode;

    typedef enum logic [3:0] {
        ST_ADDED       = 4'd0,
        ST_REFRESHED   = 4'd1,
        ST_PING_NEEDED = 4'd2,
        ST_KEPT_OLD    = 4'd3,
        ST_REPLACED    = 4'd4,
        ST_OWN_ID      = 4'd5,
        ST_BUSY        = 4'd6,
        ST_CONTACT     = 4'd7,
        ST_NONE        = 4'd8,
        ST_NO_PENDING  = 4'd9
    } t_status;

    typedef enum logic [1:0] {
        CFG_OWN_UPPER  = 2'd0,
        CFG_OWN_MIDDLE = 2'd1,
        CFG_OWN_LOWER  = 2'd2
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BKT,
        S_FILL_RD,
        S_FILL_WT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_NOTFND,
        S_EVICT_WT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH,
        S_PING,
        S_Q_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] node_id_upper;
        logic [63:0] node_id_middle;
        logic [31:0] node_id_lower;
        logic [15:0] contact;
        logic        ping_answered;
        logic [4:0]  query_count;
        logic        except_valid;
        logic [63:0] except_id_upper;
        logic [63:0] except_id_middle;
        logic [31:0] except_id_lower;
    } t_in;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  bucket;
        logic [63:0] out_id_upper;
        logic [63:0] out_id_middle;
        logic [31:0] out_id_lower;
        logic [15:0] out_contact;
        logic        last;
    } t_out;

    // bucket finder result
    typedef struct packed {
        logic       done;
        logic       same;
        logic [7:0] bucket;
    } t_bkt_res;

endpackage

// ===== design/xdbt_ram.sv =====
// generic simple dual port ram with registered read
module xdbt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/xdbt_bucket_find.sv =====
// three stage highest differing bit search between an id and the own id
module xdbt_bucket_find (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [159:0]        i_id,
    input  logic [159:0]        i_own,
    output xdbt_pkg::t_bkt_res  o_res
);
    import xdbt_pkg::*;

    logic [159:0] r_diff;
    logic         r_v1;
    logic         r_v2;
    logic [CHUNKS-1:0] r_cnz;
    logic [4:0]   r_cidx [CHUNKS];
    logic [CHUNKS-1:0] n_cnz;
    logic [4:0]   n_cidx [CHUNKS];
    t_bkt_res     r_res;
    t_bkt_res     n_res;

    // per chunk leading one
    always_comb begin
        for (int c = 0; c < CHUNKS; c++) begin
            n_cnz[c]  = |r_diff[32*c +: 32];
            n_cidx[c] = '0;
            for (int b = 0; b < 32; b++) begin
                if (r_diff[32*c + b]) begin
                    n_cidx[c] = 5'(b);
                end
            end
        end
    end

    // pick the highest nonzero chunk
    always_comb begin
        n_res.done   = r_v2;
        n_res.same   = ~|r_cnz;
        n_res.bucket = '0;
        for (int c = 0; c < CHUNKS; c++) begin
            if (r_cnz[c]) begin
                n_res.bucket = 8'(32 * c) | {3'b000, r_cidx[c]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff <= i_id ^ i_own;
        r_cnz  <= n_cnz;
        r_cidx <= n_cidx;
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_res <= '0;
        end else begin
            r_v1  <= i_go;
            r_v2  <= r_v1;
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule

// ===== design/xor_distance_bucket_table_unit.sv =====
// top level of the xor distance bucket table
// Command-style routing table of 160 buckets. An operation is taken when i_start is high
// and o_busy is low; its results appear on o_res for one cycle each, marked by o_res_valid,
// the final one with last set, and cannot be held off. Contacts live in one slot memory
// (one read and one write port) and bucket fills in a second small memory whose entries
// read as zero until first written, so no clearing pass follows reset. Each stored entry
// goes through the slot memory's read port: a read, then a compare or move. Busy updates
// and ping answers without a pending eviction answer straight from the idle state; other
// updates scan the bucket, and a refresh or eviction adds the shift of the bucket. A query
// walks the buckets from the id's bucket upward, wrapping around, reads their slots and
// stops at 20 contacts or after every bucket, skipping the excluded id where it is met.
module xor_distance_bucket_table_unit #(
    parameter int unsigned BUCKET_SLOTS = 20,
    parameter int unsigned CONTACT_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  xdbt_pkg::t_in  i_in,
    output logic           o_res_valid,
    output xdbt_pkg::t_out o_res,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [63:0]    i_cfg_data
);
    import xdbt_pkg::*;

    // handle bits kept in memory (handles are limited to 16 bits)
    localparam int unsigned HB    = (CONTACT_BITS < 16) ? CONTACT_BITS : 16;
    localparam int unsigned IW    = $clog2(BUCKET_SLOTS + 1);
    localparam int unsigned DEPTH = NUM_BUCKETS * BUCKET_SLOTS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned BW    = $clog2(NUM_BUCKETS);
    localparam int unsigned SW    = ID_BITS + HB;

    // own id registers
    logic [159:0] r_own;

    // operation registers
    t_state       r_state, n_state;
    logic [1:0]   r_op, n_op;
    logic [159:0] r_id, n_id;
    logic [HB-1:0] r_hdl, n_hdl;
    logic         r_ans, n_ans;
    logic [4:0]   r_want, n_want;
    logic         r_exv, n_exv;
    logic [159:0] r_exid, n_exid;
    logic [7:0]   r_bkt, n_bkt;
    logic [7:0]   r_start, n_start;
    logic [IW-1:0] r_fill, n_fill;
    logic [IW-1:0] r_idx, n_idx;
    logic [HB-1:0] r_keep, n_keep;
    logic         r_refresh, n_refresh;
    logic [7:0]   r_k, n_k;
    logic [4:0]   r_n, n_n;
    t_out         r_hold, n_hold;

    // eviction state
    logic         r_pend, n_pend;
    logic [7:0]   r_pbkt, n_pbkt;
    logic [159:0] r_pnew_id, n_pnew_id;
    logic [HB-1:0] r_pnew_h, n_pnew_h;
    logic [159:0] r_pold_id, n_pold_id;
    logic [HB-1:0] r_pold_h, n_pold_h;

    // result register
    logic         r_res_valid, n_res_valid;
    t_out         r_res, n_res;

    // fill valid bits, an unwritten fill reads as zero
    logic [NUM_BUCKETS-1:0] r_fvld;
    logic         r_fvld_q;

    // memory ports
    logic          s_we;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [SW-1:0] s_wdata, s_rdata;
    logic          f_we;
    logic [BW-1:0] f_waddr, f_raddr;
    logic [IW-1:0] f_wdata, f_rdata;
    logic [IW-1:0] fill_eff;
    logic [159:0]  d_id;
    logic [HB-1:0] d_h;

    logic         bk_go;
    logic [159:0] bk_id;
    t_bkt_res     bk_res;

    function automatic logic [AW-1:0] slot_addr(input logic [7:0] b, input logic [IW-1:0] i);
        slot_addr = AW'(b) * AW'(BUCKET_SLOTS) + AW'(i);
    endfunction

    function automatic t_out mk_res(input t_status st, input logic [7:0] b,
                                    input logic [159:0] id, input logic [15:0] h,
                                    input logic lst);
        t_out o;
        o.status        = st;
        o.bucket        = b;
        o.out_id_upper  = id[159:96];
        o.out_id_middle = id[95:32];
        o.out_id_lower  = id[31:0];
        o.out_contact   = h;
        o.last          = lst;
        mk_res = o;
    endfunction

    xdbt_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    xdbt_ram #(.WIDTH(IW), .DEPTH(NUM_BUCKETS)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    assign bk_id = {i_in.node_id_upper, i_in.node_id_middle, i_in.node_id_lower};

    xdbt_bucket_find u_bucket_find (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (bk_go),
        .i_id    (bk_id),
        .i_own   (r_own),
        .o_res   (bk_res)
    );

    assign fill_eff = r_fvld_q ? f_rdata : '0;
    assign d_id     = s_rdata[SW-1:HB];
    assign d_h      = s_rdata[HB-1:0];
    assign f_raddr  = BW'(r_bkt);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_id        = r_id;
        n_hdl       = r_hdl;
        n_ans       = r_ans;
        n_want      = r_want;
        n_exv       = r_exv;
        n_exid      = r_exid;
        n_bkt       = r_bkt;
        n_start     = r_start;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_keep      = r_keep;
        n_refresh   = r_refresh;
        n_k         = r_k;
        n_n         = r_n;
        n_hold      = r_hold;
        n_pend      = r_pend;
        n_pbkt      = r_pbkt;
        n_pnew_id   = r_pnew_id;
        n_pnew_h    = r_pnew_h;
        n_pold_id   = r_pold_id;
        n_pold_h    = r_pold_h;
        n_res_valid = 1'b0;
        n_res       = r_res;
        bk_go       = 1'b0;
        s_we        = 1'b0;
        s_waddr     = slot_addr(r_bkt, r_idx);
        s_wdata     = {r_id, r_hdl};
        s_raddr     = slot_addr(r_bkt, r_idx);
        f_we        = 1'b0;
        f_waddr     = BW'(r_bkt);
        f_wdata     = r_fill;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op   = i_in.opcode;
                    n_id   = bk_id;
                    n_hdl  = i_in.contact[HB-1:0];
                    n_ans  = i_in.ping_answered;
                    n_want = (i_in.query_count > 5'(MAX_RES)) ? 5'(MAX_RES) : i_in.query_count;
                    n_exv  = i_in.except_valid;
                    n_exid = {i_in.except_id_upper, i_in.except_id_middle,
                              i_in.except_id_lower};
                    case (i_in.opcode)
                        OP_UPDATE: begin
                            if (r_pend) begin
                                // eviction outstanding, nothing changes
                                n_res_valid = 1'b1;
                                n_res = mk_res(ST_BUSY, r_pbkt, bk_id,
                                               16'(i_in.contact[HB-1:0]), 1'b1);
                            end else begin
                                bk_go   = 1'b1;
                                n_state = S_BKT;
                            end
                        end
                        OP_PING: begin
                            if (!r_pend) begin
                                n_res_valid = 1'b1;
                                n_res = mk_res(ST_NO_PENDING, '0, '0, '0, 1'b1);
                            end else begin
                                n_bkt   = r_pbkt;
                                n_state = S_FILL_RD;
                            end
                        end
                        OP_QUERY: begin
                            bk_go   = 1'b1;
                            n_state = S_BKT;
                        end
                        default: begin
                            // unused code, no transaction result
                        end
                    endcase
                end
            end
            S_BKT: begin
                if (bk_res.done) begin
                    if (r_op == OP_UPDATE) begin
                        if (bk_res.same) begin
                            n_res_valid = 1'b1;
                            n_res   = mk_res(ST_OWN_ID, '0, r_id, 16'(r_hdl), 1'b1);
                            n_state = S_IDLE;
                        end else begin
                            n_bkt   = bk_res.bucket;
                            n_state = S_FILL_RD;
                        end
                    end else begin
                        n_bkt   = bk_res.same ? '0 : bk_res.bucket;
                        n_start = bk_res.same ? '0 : bk_res.bucket;
                        n_k     = '0;
                        n_n     = '0;
                        n_state = (r_want == '0) ? S_Q_DONE : S_FILL_RD;
                    end
                end
            end
            S_FILL_RD: begin
                n_state = S_FILL_WT;
            end
            S_FILL_WT: begin
                n_fill = fill_eff;
                n_idx  = '0;
                case (r_op)
                    OP_UPDATE: n_state = (fill_eff == '0) ? S_NOTFND : S_SCAN_RD;
                    OP_PING:   n_state = S_PING;
                    default: begin
                        if (fill_eff != '0) begin
                            n_state = S_SCAN_RD;
                        end else if (r_k == 8'(NUM_BUCKETS - 1)) begin
                            n_state = S_Q_DONE;
                        end else begin
                            n_k     = r_k + 8'd1;
                            n_bkt   = (r_bkt == 8'(NUM_BUCKETS - 1)) ? '0 : r_bkt + 8'd1;
                            n_state = S_FILL_RD;
                        end
                    end
                endcase
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (r_op == OP_UPDATE) begin
                    if (d_id == r_id) begin
                        // known id keeps its handle and moves to newest
                        n_keep    = d_h;
                        n_refresh = 1'b1;
                        n_state   = S_SHIFT_RD;
                    end else if (r_idx + IW'(1) == r_fill) begin
                        n_state = S_NOTFND;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    // one result held back so that the final one can carry last
                    if (!(r_exv && d_id == r_exid)) begin
                        if (r_n != '0) begin
                            n_res_valid = 1'b1;
                            n_res       = r_hold;
                        end
                        n_hold = mk_res(ST_CONTACT, r_bkt, d_id, 16'(d_h), 1'b0);
                        n_n    = r_n + 5'd1;
                    end
                    if (!(r_exv && d_id == r_exid) && (r_n + 5'd1 == r_want)) begin
                        n_state = S_Q_DONE;
                    end else if (r_idx + IW'(1) != r_fill) begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_SCAN_RD;
                    end else if (r_k == 8'(NUM_BUCKETS - 1)) begin
                        n_state = S_Q_DONE;
                    end else begin
                        n_k     = r_k + 8'd1;
                        n_bkt   = (r_bkt == 8'(NUM_BUCKETS - 1)) ? '0 : r_bkt + 8'd1;
                        n_state = S_FILL_RD;
                    end
                end
            end
            S_NOTFND: begin
                if (r_fill < IW'(BUCKET_SLOTS)) begin
                    s_we        = 1'b1;
                    s_waddr     = slot_addr(r_bkt, r_fill);
                    f_we        = 1'b1;
                    f_wdata     = r_fill + IW'(1);
                    n_res_valid = 1'b1;
                    n_res       = mk_res(ST_ADDED, r_bkt, r_id, 16'(r_hdl), 1'b1);
                    n_state     = S_IDLE;
                end else begin
                    // full bucket, fetch the oldest entry for eviction
                    s_raddr = slot_addr(r_bkt, '0);
                    n_state = S_EVICT_WT;
                end
            end
            S_EVICT_WT: begin
                n_pold_id = d_id;
                n_pold_h  = d_h;
                n_refresh = 1'b0;
                n_idx     = '0;
                n_state   = S_SHIFT_RD;
            end
            S_SHIFT_RD: begin
                if (r_idx + IW'(1) < r_fill) begin
                    s_raddr = slot_addr(r_bkt, r_idx + IW'(1));
                    n_state = S_SHIFT_WR;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT_WR: begin
                s_we    = 1'b1;
                s_wdata = s_rdata;
                n_idx   = r_idx + IW'(1);
                n_state = S_SHIFT_RD;
            end
            S_FINISH: begin
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
                if (r_refresh) begin
                    s_we    = 1'b1;
                    s_waddr = slot_addr(r_bkt, r_fill - IW'(1));
                    s_wdata = {r_id, r_keep};
                    n_res   = mk_res(ST_REFRESHED, r_bkt, r_id, 16'(r_keep), 1'b1);
                end else begin
                    f_we      = 1'b1;
                    f_wdata   = r_fill - IW'(1);
                    n_pend    = 1'b1;
                    n_pbkt    = r_bkt;
                    n_pnew_id = r_id;
                    n_pnew_h  = r_hdl;
                    n_res     = mk_res(ST_PING_NEEDED, r_bkt, r_pold_id, 16'(r_pold_h), 1'b1);
                end
            end
            S_PING: begin
                s_we        = 1'b1;
                s_waddr     = slot_addr(r_bkt, r_fill);
                s_wdata     = r_ans ? {r_pold_id, r_pold_h} : {r_pnew_id, r_pnew_h};
                f_we        = 1'b1;
                f_wdata     = r_fill + IW'(1);
                n_pend      = 1'b0;
                n_res_valid = 1'b1;
                n_res       = r_ans ?
                              mk_res(ST_KEPT_OLD, r_bkt, r_pold_id, 16'(r_pold_h), 1'b1) :
                              mk_res(ST_REPLACED, r_bkt, r_pnew_id, 16'(r_pnew_h), 1'b1);
                n_state     = S_IDLE;
            end
            S_Q_DONE: begin
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
                if (r_n == '0) begin
                    n_res = mk_res(ST_NONE, r_start, '0, '0, 1'b1);
                end else begin
                    n_res      = r_hold;
                    n_res.last = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
            r_fvld      <= '0;
            r_fvld_q    <= 1'b0;
            r_own       <= '0;
            r_pbkt      <= '0;
            r_pnew_id   <= '0;
            r_pnew_h    <= '0;
            r_pold_id   <= '0;
            r_pold_h    <= '0;
        end else begin
            r_pend      <= n_pend;
            r_res_valid <= n_res_valid;
            r_fvld_q    <= r_fvld[f_raddr];
            r_pbkt      <= n_pbkt;
            r_pnew_id   <= n_pnew_id;
            r_pnew_h    <= n_pnew_h;
            r_pold_id   <= n_pold_id;
            r_pold_h    <= n_pold_h;
            if (f_we) begin
                r_fvld[f_waddr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_OWN_UPPER:  r_own[159:96] <= i_cfg_data;
                    CFG_OWN_MIDDLE: r_own[95:32]  <= i_cfg_data;
                    CFG_OWN_LOWER:  r_own[31:0]   <= i_cfg_data[31:0];
                    default: begin
                        // no register at this index
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_id      <= n_id;
        r_hdl     <= n_hdl;
        r_ans     <= n_ans;
        r_want    <= n_want;
        r_exv     <= n_exv;
        r_exid    <= n_exid;
        r_bkt     <= n_bkt;
        r_start   <= n_start;
        r_fill    <= n_fill;
        r_idx     <= n_idx;
        r_keep    <= n_keep;
        r_refresh <= n_refresh;
        r_k       <= n_k;
        r_n       <= n_n;
        r_hold    <= n_hold;
        r_res     <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    // a reported eviction leaves a pending ping behind
    a_ping_sets_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_PING_NEEDED) |-> r_pend)
        else $error("eviction reported without pending ping");

    // update during a pending eviction is refused in the next cycle
    a_busy_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && r_pend && i_in.opcode == OP_UPDATE)
        |=> (o_res_valid && o_res.status == ST_BUSY && o_res.last))
        else $error("busy update not refused");

    // a bucket fill never exceeds its slot count
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_we |-> (f_wdata <= IW'(BUCKET_SLOTS)))
        else $error("bucket fill overflow");

    // a contact result names an existing bucket
    a_contact_bucket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_CONTACT) |-> (o_res.bucket < 8'(NUM_BUCKETS)))
        else $error("contact from a bucket out of range");
`endif

endmodule
